// ===== rtl/core/g2e_pkg.sv =====
// ----------------------------------------------------------------------------
// g2e_pkg
// shared constants and elaboration-time table functions for the geodetic to
// ecef converter
// ----------------------------------------------------------------------------
package g2e_pkg;

  localparam int unsigned CORDIC_STAGES = 32;
  localparam int unsigned NEWTON_ITERS  = 10;

  localparam logic [63:0] CAP     = 64'd1 << 62;
  localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
  localparam logic [63:0] KDEG    = (PI_Q60 + 64'd90) / 64'd180;
  localparam logic [63:0] D_MIN   = 64'd1 << 22;
  localparam logic [63:0] Y_INIT  = 64'd3 << 59;
  localparam logic [63:0] THREE   = 64'd3 << 60;

  localparam logic [32:0] DEG_FULL    = 33'd3019898880;
  localparam logic [32:0] DEG_QUARTER = 33'd754974720;
  localparam logic [32:0] DEG_EIGHTH  = 33'd377487360;

  localparam logic signed [63:0] OUT_LIM = 64'sd120000000000;

  localparam int unsigned A_W = 34;
  localparam int unsigned F_W = 40;
  localparam logic [A_W-1:0] A_RESET = 34'd6378137000;
  localparam logic [F_W-1:0] F_RESET = 40'd3686454311;

  localparam logic REG_SEMI_MAJOR = 1'b0;
  localparam logic REG_FLATTENING = 1'b1;

  // rounded, saturating product, constant evaluation only
  function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
                                          input int unsigned s);
    logic [127:0] p;
    p = 128'(a) * 128'(b) + (128'd1 << (s - 1));
    p = p >> s;
    return (p > 128'(CAP)) ? CAP : p[63:0];
  endfunction

  // arctan(2^-i) in radians q60 from the power series
  function automatic logic signed [63:0] atan_q60(input int unsigned i);
    logic signed [63:0] acc;
    logic [63:0]        term;
    int unsigned        k;
    int unsigned        e;
    acc = '0;
    if (i == 0) begin
      acc = $signed(PI_Q60 >> 2);
    end else begin
      k = 0;
      e = i;
      while (e <= 60) begin
        term = (64'd1 << (60 - e)) / 64'(2 * k + 1);
        if (k[0]) begin
          acc = acc - $signed(term);
        end else begin
          acc = acc + $signed(term);
        end
        k = k + 1;
        e = i * (2 * k + 1);
      end
    end
    return acc;
  endfunction

  // start vector length, the inverse of the rotation gain
  function automatic logic [63:0] cordic_gain(input int unsigned stages);
    logic [63:0] p;
    logic [63:0] y;
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] v;
    p = 64'd1 << 60;
    for (int unsigned i = 0; i < stages; i++) begin
      if (2 * i < 62) p = p + (p >> (2 * i));
    end
    y = Y_INIT;
    for (int unsigned it = 0; it < NEWTON_ITERS; it++) begin
      t = mul_shr(y, y, 60);
      u = mul_shr(p, t, 62);
      v = (u >= THREE) ? 64'd0 : THREE - u;
      y = mul_shr(y, v, 61);
    end
    return y;
  endfunction

endpackage

// ===== rtl/core/g2e_mul.sv =====
// ----------------------------------------------------------------------------
// g2e_mul
// two-stage 64x64 unsigned multiplier, rounds to nearest after a right shift
// and saturates at 2^62
// ----------------------------------------------------------------------------
module g2e_mul (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  input  logic [6:0]  sh_i,
  output logic [63:0] p_o
);

  logic [63:0]  p00_q, p01_q, p10_q, p11_q;
  logic [6:0]   sh_q;
  logic [63:0]  p_q;
  logic [127:0] prod, rsum, rsh;
  logic [63:0]  p_d;

  // 32x32 partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p00_q <= 64'(a_i[31:0])  * 64'(b_i[31:0]);
      p01_q <= 64'(a_i[31:0])  * 64'(b_i[63:32]);
      p10_q <= 64'(a_i[63:32]) * 64'(b_i[31:0]);
      p11_q <= 64'(a_i[63:32]) * 64'(b_i[63:32]);
      sh_q  <= sh_i;
    end
  end

  always_comb begin
    prod = {64'd0, p00_q} + ({64'd0, p01_q} << 32) + ({64'd0, p10_q} << 32)
         + {p11_q, 64'd0};
    rsum = prod + (128'd1 << (sh_q - 7'd1));
    rsh  = rsum >> sh_q;
    p_d  = (rsh > {64'd0, g2e_pkg::CAP}) ? g2e_pkg::CAP : rsh[63:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

// ===== rtl/core/g2e_cordic.sv =====
// ----------------------------------------------------------------------------
// g2e_cordic
// pipelined rotation cordic giving cosine and sine (q61) of a reduced angle,
// followed by the quadrant fold
// ----------------------------------------------------------------------------
module g2e_cordic #(
  parameter int unsigned STAGES = g2e_pkg::CORDIC_STAGES
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [63:0]        zmag_i,
  input  logic               zneg_i,
  input  logic [1:0]         quad_i,
  output logic signed [63:0] cos_o,
  output logic signed [63:0] sin_o
);

  localparam logic signed [63:0] X0 = $signed(g2e_pkg::cordic_gain(STAGES));

  logic signed [63:0] x_q [STAGES+1];
  logic signed [63:0] y_q [STAGES+1];
  logic signed [63:0] z_q [STAGES+1];
  logic [1:0]         quad_q [STAGES+1];
  logic signed [63:0] cos_q, sin_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= X0;
      y_q[0]    <= '0;
      z_q[0]    <= zneg_i ? -$signed(zmag_i) : $signed(zmag_i);
      quad_q[0] <= quad_i;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    localparam logic signed [63:0] ATAN = g2e_pkg::atan_q60(i);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quad_q[i+1] <= quad_q[i];
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - ATAN;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + ATAN;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      unique case (quad_q[STAGES])
        2'd0: begin
          cos_q <= x_q[STAGES];
          sin_q <= y_q[STAGES];
        end
        2'd1: begin
          cos_q <= -y_q[STAGES];
          sin_q <= x_q[STAGES];
        end
        2'd2: begin
          cos_q <= -x_q[STAGES];
          sin_q <= -y_q[STAGES];
        end
        default: begin
          cos_q <= y_q[STAGES];
          sin_q <= -x_q[STAGES];
        end
      endcase
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

// ===== rtl/core/geodetic_to_ecef_top.sv =====
// ----------------------------------------------------------------------------
// geodetic_to_ecef_top
// Converts latitude, longitude and height on the configured ellipsoid to
// geocentric X, Y, Z in millimetres. One point is taken per clock cycle
// while the output is not stalled. The datapath runs through the two rotation
// CORDICs, the ten-step Newton reciprocal square root (three multipliers a
// step) and the final multiplies. A stall on the output holds the whole
// pipeline. The ellipsoid registers are to be written by the user only while
// no point is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module geodetic_to_ecef_top #(
  parameter int unsigned CORDIC_STAGES = g2e_pkg::CORDIC_STAGES
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,   // lat_deg[30:0], lon_deg[63:31], height_mm[101:64]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [119:0] m_axis_tdata,   // x_coord[37:0], y_coord[75:38], z_coord[113:76]
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [39:0]  cfg_data_i
);

  localparam int unsigned NEWTON_LAT = g2e_pkg::NEWTON_ITERS * 7;
  localparam int unsigned LAT        = CORDIC_STAGES + 97;
  localparam int unsigned CL_DLY     = 81;
  localparam int unsigned TRIG_DLY   = 85;
  localparam int unsigned H_DLY      = CORDIC_STAGES + 86;

  localparam logic signed [34:0] FULL_S = 35'(g2e_pkg::DEG_FULL);

  function automatic logic [63:0] umag(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  logic adv;
  logic [LAT-1:0] vld_q;

  assign adv           = m_axis_tready | ~vld_q[LAT-1];
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // ellipsoid registers
  logic [g2e_pkg::A_W-1:0] semi_q;
  logic [g2e_pkg::F_W-1:0] flat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      semi_q <= g2e_pkg::A_RESET;
      flat_q <= g2e_pkg::F_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        g2e_pkg::REG_SEMI_MAJOR: semi_q <= cfg_data_i[g2e_pkg::A_W-1:0];
        g2e_pkg::REG_FLATTENING: flat_q <= cfg_data_i[g2e_pkg::F_W-1:0];
        default: ;
      endcase
    end
  end

  // e^2 and (1-f)^2 follow the registers, settled long before any use
  logic [63:0] e2_w, fs_w, om_w;
  assign om_w = (64'd1 << 40) - 64'(flat_q);

  g2e_mul u_e2 (
    .clk_i, .en_i(1'b1), .a_i(64'(flat_q)), .b_i((64'd1 << 41) - 64'(flat_q)),
    .sh_i(7'd18), .p_o(e2_w)
  );
  g2e_mul u_fs (
    .clk_i, .en_i(1'b1), .a_i(om_w), .b_i(om_w), .sh_i(7'd18), .p_o(fs_w)
  );

  // input request
  logic signed [30:0] lat_q;
  logic signed [32:0] lon_q;
  logic signed [37:0] h_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lat_q <= s_axis_tdata[30:0];
      lon_q <= s_axis_tdata[63:31];
      h_q   <= s_axis_tdata[101:64];
    end
  end

  // angle reduction: wrap to a full turn, then to a quadrant and a remainder
  logic signed [34:0] ang_w [2];
  logic signed [63:0] cos_w [2];
  logic signed [63:0] sin_w [2];

  assign ang_w[0] = 35'(lat_q);
  assign ang_w[1] = 35'(lon_q);

  for (genvar j = 0; j < 2; j++) begin : g_ang
    logic signed [34:0] am_c;
    logic [31:0]        am_q;
    logic [32:0]        qv_c;
    logic [32:0]        base_c;
    logic [2:0]         q_c;
    logic signed [33:0] r_c;
    logic [28:0]        rmag_q;
    logic               rneg_q, rneg1_q, rneg2_q;
    logic [1:0]         quad_q, quad1_q, quad2_q;
    logic [63:0]        zmag_w;

    always_comb begin
      priority if (ang_w[j] < -FULL_S) begin
        am_c = ang_w[j] + FULL_S + FULL_S;
      end else if (ang_w[j] < 0) begin
        am_c = ang_w[j] + FULL_S;
      end else if (ang_w[j] >= FULL_S) begin
        am_c = ang_w[j] - FULL_S;
      end else begin
        am_c = ang_w[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        am_q <= am_c[31:0];
      end
    end

    always_comb begin
      qv_c = 33'(am_q) + g2e_pkg::DEG_EIGHTH;
      priority if (qv_c >= 33'(4) * g2e_pkg::DEG_QUARTER) begin
        q_c = 3'd4;
      end else if (qv_c >= 33'(3) * g2e_pkg::DEG_QUARTER) begin
        q_c = 3'd3;
      end else if (qv_c >= 33'(2) * g2e_pkg::DEG_QUARTER) begin
        q_c = 3'd2;
      end else if (qv_c >= g2e_pkg::DEG_QUARTER) begin
        q_c = 3'd1;
      end else begin
        q_c = 3'd0;
      end
      base_c = 33'(q_c) * g2e_pkg::DEG_QUARTER;
      r_c    = $signed({2'b00, am_q}) - $signed({1'b0, base_c});
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rneg_q  <= r_c[33];
        rmag_q  <= r_c[33] ? 29'(-r_c) : r_c[28:0];
        quad_q  <= q_c[1:0];
        rneg1_q <= rneg_q;
        rneg2_q <= rneg1_q;
        quad1_q <= quad_q;
        quad2_q <= quad1_q;
      end
    end

    // degrees to radians q60
    g2e_mul u_z (
      .clk_i, .en_i(adv), .a_i(64'(rmag_q)), .b_i(g2e_pkg::KDEG), .sh_i(7'd23),
      .p_o(zmag_w)
    );

    g2e_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
      .clk_i, .en_i(adv), .zmag_i(zmag_w), .zneg_i(rneg2_q), .quad_i(quad2_q),
      .cos_o(cos_w[j]), .sin_o(sin_w[j])
    );
  end

  // 1 - e^2 sin^2 lat
  logic [63:0] slm_q, s2_w, t_w, d_c, d_q, dl_q, dn_q;
  logic [5:0]  lz_c;
  logic [4:0]  k_c, k_q, kn_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      slm_q <= umag(sin_w[0]);
    end
  end

  g2e_mul u_s2 (
    .clk_i, .en_i(adv), .a_i(slm_q), .b_i(slm_q), .sh_i(7'd60), .p_o(s2_w)
  );
  g2e_mul u_t (
    .clk_i, .en_i(adv), .a_i(e2_w), .b_i(s2_w), .sh_i(7'd62), .p_o(t_w)
  );

  assign d_c = (g2e_pkg::CAP - t_w < g2e_pkg::D_MIN) ? g2e_pkg::D_MIN : g2e_pkg::CAP - t_w;

  // leading-one search, then normalise by pairs of bits
  always_comb begin
    lz_c = '0;
    for (int i = 0; i < 60; i++) begin
      if (d_q[i]) lz_c = 6'(59 - i);
    end
    k_c = (d_q[62:60] != 3'd0) ? 5'd0 : 5'((7'(lz_c) + 7'd2) >> 1);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_q  <= d_c;
      dl_q <= d_q;
      k_q  <= k_c;
      dn_q <= dl_q << {k_q, 1'b0};
      kn_q <= k_q;
    end
  end

  // newton steps for 1/sqrt
  logic [63:0] ny_w [g2e_pkg::NEWTON_ITERS+1];
  logic [63:0] nd_w [g2e_pkg::NEWTON_ITERS+1];

  assign ny_w[0] = g2e_pkg::Y_INIT;
  assign nd_w[0] = dn_q;

  for (genvar j = 0; j < g2e_pkg::NEWTON_ITERS; j++) begin : g_newton
    logic [63:0] tt_w, u_w, v_q;
    logic [63:0] yd_q [5];
    logic [63:0] dd_q [7];

    always_ff @(posedge clk_i) begin
      if (adv) begin
        yd_q[0] <= ny_w[j];
        for (int i = 1; i < 5; i++) yd_q[i] <= yd_q[i-1];
        dd_q[0] <= nd_w[j];
        for (int i = 1; i < 7; i++) dd_q[i] <= dd_q[i-1];
        v_q <= (u_w >= g2e_pkg::THREE) ? 64'd0 : g2e_pkg::THREE - u_w;
      end
    end

    g2e_mul u_yy (
      .clk_i, .en_i(adv), .a_i(ny_w[j]), .b_i(ny_w[j]), .sh_i(7'd60), .p_o(tt_w)
    );
    g2e_mul u_dt (
      .clk_i, .en_i(adv), .a_i(dd_q[1]), .b_i(tt_w), .sh_i(7'd62), .p_o(u_w)
    );
    g2e_mul u_yv (
      .clk_i, .en_i(adv), .a_i(yd_q[4]), .b_i(v_q), .sh_i(7'd61),
      .p_o(ny_w[j+1])
    );
    assign nd_w[j+1] = dd_q[6];
  end

  logic [4:0] kd_q [NEWTON_LAT];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kd_q[0] <= kn_q;
      for (int i = 1; i < NEWTON_LAT; i++) kd_q[i] <= kd_q[i-1];
    end
  end

  // prime-vertical radius and the polar form
  logic [63:0] nq_w, nb_w;

  g2e_mul u_nq (
    .clk_i, .en_i(adv), .a_i(64'(semi_q)), .b_i(ny_w[g2e_pkg::NEWTON_ITERS]),
    .sh_i(7'd44 - 7'(kd_q[NEWTON_LAT-1])), .p_o(nq_w)
  );
  g2e_mul u_nb (
    .clk_i, .en_i(adv), .a_i(nq_w), .b_i(fs_w), .sh_i(7'd62), .p_o(nb_w)
  );

  logic signed [37:0] hd_q [H_DLY];
  logic signed [37:0] hd2_q [2];
  logic signed [63:0] g1_q, g2_q;
  logic signed [63:0] g2d_q [2];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hd_q[0] <= h_q;
      for (int i = 1; i < H_DLY; i++) hd_q[i] <= hd_q[i-1];
      hd2_q[0] <= hd_q[H_DLY-1];
      hd2_q[1] <= hd2_q[0];
      // heights go to 16 fraction bits
      g1_q     <= $signed(nq_w) + (64'(hd_q[H_DLY-1]) <<< 16);
      g2_q     <= $signed(nb_w) + (64'(hd2_q[1]) <<< 16);
      g2d_q[0] <= g2_q;
      g2d_q[1] <= g2d_q[0];
    end
  end

  // trig values held until their products
  logic signed [63:0] cld_q [CL_DLY];
  logic signed [63:0] cod_q [TRIG_DLY];
  logic signed [63:0] sod_q [TRIG_DLY];
  logic signed [63:0] sld_q [TRIG_DLY];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cld_q[0] <= cos_w[0];
      for (int i = 1; i < CL_DLY; i++) cld_q[i] <= cld_q[i-1];
      cod_q[0] <= cos_w[1];
      sod_q[0] <= sin_w[1];
      sld_q[0] <= sin_w[0];
      for (int i = 1; i < TRIG_DLY; i++) begin
        cod_q[i] <= cod_q[i-1];
        sod_q[i] <= sod_q[i-1];
        sld_q[i] <= sld_q[i-1];
      end
    end
  end

  // (N + h) cos lat
  logic [63:0]        xam_q, xbm_q, xp_w;
  logic               xneg_q, xneg1_q, xneg2_q;
  logic signed [63:0] xc_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xam_q   <= umag(g1_q);
      xbm_q   <= umag(cld_q[CL_DLY-1]);
      xneg_q  <= g1_q[63] ^ cld_q[CL_DLY-1][63];
      xneg1_q <= xneg_q;
      xneg2_q <= xneg1_q;
      xc_q    <= xneg2_q ? -$signed(xp_w) : $signed(xp_w);
    end
  end

  g2e_mul u_xc (
    .clk_i, .en_i(adv), .a_i(xam_q), .b_i(xbm_q), .sh_i(7'd61), .p_o(xp_w)
  );

  // final products and rounding to millimetres
  logic signed [63:0] fa_w [3];
  logic signed [63:0] fb_w [3];
  logic [37:0]        out_q [3];

  assign fa_w[0] = xc_q;
  assign fa_w[1] = xc_q;
  assign fa_w[2] = g2d_q[1];
  assign fb_w[0] = cod_q[TRIG_DLY-1];
  assign fb_w[1] = sod_q[TRIG_DLY-1];
  assign fb_w[2] = sld_q[TRIG_DLY-1];

  for (genvar j = 0; j < 3; j++) begin : g_out
    logic [63:0]        am_q, bm_q, p_w;
    logic               neg_q, neg1_q, neg2_q;
    logic signed [63:0] v_q, w_c;

    assign w_c = (v_q + 64'sd32768) >>> 16;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        am_q   <= umag(fa_w[j]);
        bm_q   <= umag(fb_w[j]);
        neg_q  <= fa_w[j][63] ^ fb_w[j][63];
        neg1_q <= neg_q;
        neg2_q <= neg1_q;
        v_q    <= neg2_q ? -$signed(p_w) : $signed(p_w);
        priority if (w_c > g2e_pkg::OUT_LIM) begin
          out_q[j] <= g2e_pkg::OUT_LIM[37:0];
        end else if (w_c < -g2e_pkg::OUT_LIM) begin
          out_q[j] <= 38'(-g2e_pkg::OUT_LIM);
        end else begin
          out_q[j] <= w_c[37:0];
        end
      end
    end

    g2e_mul u_f (
      .clk_i, .en_i(adv), .a_i(am_q), .b_i(bm_q), .sh_i(7'd61), .p_o(p_w)
    );
  end

  assign m_axis_tdata = {6'd0, out_q[2], out_q[1], out_q[0]};

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Geodetic to ECEF converter check: requests of latitude, longitude and
// height go in on the input stream, every X, Y, Z result is compared with a
// bit-exact fixed-point model of the datapath, over several ellipsoids.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned STAGES  = g2e_pkg::CORDIC_STAGES;
  localparam int unsigned LATENCY = STAGES + 97;
  localparam longint      LAT_MAX = 64'sd754974720;
  localparam longint      LON_MIN = -64'sd1509949440;
  localparam longint      LON_MAX = 64'sd3019898880;
  localparam longint      H_MIN   = -64'sd100000000;
  localparam longint      H_MAX   = 64'sd100000000000;

  typedef struct packed {
    logic signed [37:0] x;
    logic signed [37:0] y;
    logic signed [37:0] z;
  } ecef_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [119:0] m_axis_tdata;
  logic         cfg_we_i = 1'b0;
  logic         cfg_idx_i = 1'b0;
  logic [39:0]  cfg_data_i = '0;

  geodetic_to_ecef_top dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  int    hold_cycles = 0;
  int    errors = 0;
  ecef_t pending_points[$];

  logic [63:0] axis_mm;
  logic [63:0] flat_frac;
  logic signed [63:0] atan_rad[STAGES];
  logic signed [63:0] gain_x0;

  // ---------------------------------------------------------------- model
  function automatic logic [63:0] rmul(logic [63:0] a, logic [63:0] b, int unsigned s);
    logic [127:0] p;
    p = 128'(a) * 128'(b) + (128'd1 << (s - 1));
    p = p >> s;
    return (p > 128'(64'd1 << 62)) ? (64'd1 << 62) : p[63:0];
  endfunction

  function automatic logic [63:0] mag(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [63:0] inv_sqrt(logic [63:0] d, output int unsigned k);
    logic [63:0] r;
    logic [63:0] u;
    r = 64'd3 << 59;
    k = 0;
    while (d < (64'd1 << 60)) begin
      d = d << 2;
      k++;
    end
    for (int i = 0; i < 10; i++) begin
      u = rmul(d, rmul(r, r, 60), 62);
      r = rmul(r, (u >= (64'd3 << 60)) ? 64'd0 : (64'd3 << 60) - u, 61);
    end
    return r;
  endfunction

  task automatic build_rotation_tables();
    logic [63:0] p;
    logic signed [63:0] acc;
    int unsigned k;
    int unsigned e;
    p = 64'd1 << 60;
    for (int i = 0; i < STAGES; i++) begin
      if (i == 0) begin
        acc = $signed(g2e_pkg::PI_Q60 >> 2);
      end else begin
        acc = 0;
        k = 0;
        e = i;
        while (e <= 60) begin
          if (k[0]) acc -= $signed((64'd1 << (60 - e)) / 64'(2 * k + 1));
          else acc += $signed((64'd1 << (60 - e)) / 64'(2 * k + 1));
          k++;
          e = i * (2 * k + 1);
        end
      end
      atan_rad[i] = acc;
      if (2 * i < 62) p = p + (p >> (2 * i));
    end
    gain_x0 = inv_sqrt(p, k);
  endtask

  function automatic void rotate(input logic signed [63:0] ang,
                                 output logic signed [63:0] c,
                                 output logic signed [63:0] s);
    logic signed [63:0] am;
    logic signed [63:0] q;
    logic signed [63:0] r;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    am = ang % 64'sd3019898880;
    if (am < 0) am += 64'sd3019898880;
    q = (am + 64'sd377487360) / 64'sd754974720;
    r = am - q * 64'sd754974720;
    z = $signed(rmul(mag(r), g2e_pkg::KDEG, 23));
    if (r < 0) z = -z;
    x = gain_x0;
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_rad[i];
      end else begin
        x += dx; y -= dy; z += atan_rad[i];
      end
    end
    case (q[1:0])
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic logic signed [63:0] fmul(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [63:0] r;
    r = $signed(rmul(mag(a), mag(b), 61));
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic logic signed [37:0] round_mm(logic signed [63:0] v);
    logic signed [63:0] w;
    w = (v + 64'sd32768) >>> 16;
    if (w > g2e_pkg::OUT_LIM) w = g2e_pkg::OUT_LIM;
    if (w < -g2e_pkg::OUT_LIM) w = -g2e_pkg::OUT_LIM;
    return w[37:0];
  endfunction

  function automatic ecef_t geodetic_to_ecef(logic signed [30:0] lat,
      logic signed [32:0] lon, logic signed [37:0] h);
    logic signed [63:0] cl, sl, co, so, g1, g2, xc, hq;
    logic [63:0] e2, d, r, nq, om, nb;
    int unsigned k;
    ecef_t res;
    rotate(64'(lat), cl, sl);
    rotate(64'(lon), co, so);
    e2 = rmul(flat_frac, (64'd1 << 41) - flat_frac, 18);
    d = (64'd1 << 62) - rmul(e2, rmul(mag(sl), mag(sl), 60), 62);
    if (d < g2e_pkg::D_MIN) d = g2e_pkg::D_MIN;
    r = inv_sqrt(d, k);
    nq = rmul(64'(axis_mm), r, 44 - k);
    om = (64'd1 << 40) - flat_frac;
    nb = rmul(nq, rmul(om, om, 18), 62);
    hq = 64'(h) * 64'sd65536;
    g1 = $signed(nq) + hq;
    g2 = $signed(nb) + hq;
    xc = fmul(g1, cl);
    res.x = round_mm(fmul(xc, co));
    res.y = round_mm(fmul(xc, so));
    res.z = round_mm(fmul(g2, sl));
    return res;
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_point(logic signed [30:0] lat, logic signed [32:0] lon,
                            logic signed [37:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b0, h, lon, lat};
    pending_points.push_back(geodetic_to_ecef(lat, lon, h));
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain();
    int guard;
    s_axis_tvalid <= 1'b0;
    guard = 0;
    while (pending_points.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [39:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    if (idx == g2e_pkg::REG_SEMI_MAJOR) axis_mm = 64'(val[33:0]);
    else flat_frac = 64'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // receiver: random stalls plus a requested long hold-off
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    ecef_t got;
    ecef_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.x = m_axis_tdata[37:0];
      got.y = m_axis_tdata[75:38];
      got.z = m_axis_tdata[113:76];
      if (pending_points.size() == 0) begin
        $display("%0t unexpected result x=%0d y=%0d z=%0d", $time, got.x, got.y, got.z);
        errors++;
      end else begin
        want = pending_points.pop_front();
        if (got.x !== want.x) begin
          $display("%0t x mismatch: expected %0d actual %0d", $time, want.x, got.x);
          errors++;
        end
        if (got.y !== want.y) begin
          $display("%0t y mismatch: expected %0d actual %0d", $time, want.y, got.y);
          errors++;
        end
        if (got.z !== want.z) begin
          $display("%0t z mismatch: expected %0d actual %0d", $time, want.z, got.z);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests
  function automatic logic signed [63:0] rand_span(longint lo, longint hi);
    logic [63:0] u;
    u = {$urandom, $urandom};
    return lo + longint'(u % 64'(hi - lo + 1));
  endfunction

  task automatic test_extremes();
    longint lats[5] = '{-LAT_MAX, LAT_MAX, 0, 64'sd377487360, -64'sd1};
    longint lons[6] = '{LON_MIN, LON_MAX, 0, 64'sd754974720, -64'sd377487360, 64'sd1};
    longint hs[4] = '{H_MIN, H_MAX, 0, 64'sd1000};
    for (int i = 0; i < 12; i++)
      send_point(31'(lats[i % 5]), 33'(lons[i % 6]), 38'(hs[i % 4]));
    // large positive, most negative, all-ones and alternating bit patterns of the fields
    send_point(31'h3fffffff, 33'h0ffffffff, 38'h0fffffffff);
    send_point(31'h40000000, 33'h100000000, 38'h2000000000);
    send_point(31'h7fffffff, 33'h1ffffffff, 38'h3fffffffff);
    send_point(31'h2aaaaaaa, 33'h155555555, 38'h1555555555);
  endtask

  task automatic test_random(int n);
    longint lat;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: lat = 64'({$urandom});
        1: lat = rand_span(-LAT_MAX, LAT_MAX) | 64'sd0;
        default: lat = rand_span(-LAT_MAX, LAT_MAX);
      endcase
      send_point(lat[30:0],
                 ($urandom_range(9) == 0) ? 33'({$urandom, $urandom})
                                          : 33'(rand_span(LON_MIN, LON_MAX)),
                 ($urandom_range(9) == 0) ? 38'({$urandom, $urandom})
                                          : 38'(rand_span(H_MIN, H_MAX)));
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    test_random(300);
    drain();
  endtask

  task automatic test_ellipsoids();
    logic [39:0] axes[4] = '{40'd1, 40'd10000000000, 40'd0, 40'h3ffffffff};
    logic [39:0] flats[4] = '{40'd0, 40'd549755813888, 40'hffffffffff, 40'd3686454311};
    for (int i = 0; i < 4; i++) begin
      write_reg(g2e_pkg::REG_SEMI_MAJOR, axes[i]);
      write_reg(g2e_pkg::REG_FLATTENING, flats[i]);
      test_extremes();
      test_random(60);
      drain();
    end
    write_reg(g2e_pkg::REG_SEMI_MAJOR, 40'(g2e_pkg::A_RESET));
    write_reg(g2e_pkg::REG_FLATTENING, 40'(g2e_pkg::F_RESET));
  endtask

  initial begin
    axis_mm = 64'(g2e_pkg::A_RESET);
    flat_frac = 64'(g2e_pkg::F_RESET);
    build_rotation_tables();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 36; recv_idle_pct = 76;
    test_extremes();
    test_random(500);
    drain();
    test_ellipsoids();
    send_idle_pct = 76; recv_idle_pct = 36;
    test_random(500);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(400);
    test_backpressure();
    if (errors == 0 && pending_points.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
